### hdl/slu_pkg.sv
// Shared types, codes and character helpers for the string literal unescaper.
// Used by slu_decode, slu_out_fifo and string_literal_unescaper.
package slu_pkg;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_BSL   = 8'h5C;
    localparam logic [7:0] ESC_BYTE   = 8'h1B;
    localparam logic [7:0] DIGIT_NONE = 8'hFF;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic       last;
    } t_result;

    // Up to two results caused by one request, in delivery order.
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_pair;

    function automatic logic [7:0] slu_digit(input logic [7:0] c);
        logic [7:0] v;
        v = DIGIT_NONE;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            v = c - 8'h61 + 8'd10;
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            v = c - 8'h41 + 8'd10;
        end
        return v;
    endfunction

    // Map a letter after a backslash to its control byte (s gives a space); others pass through.
    function automatic logic [7:0] slu_escape(input logic [7:0] c);
        logic [7:0] v;
        unique case (c)
            8'h61: v = 8'd7;     // a
            8'h6E: v = 8'd10;    // n
            8'h72: v = 8'd13;    // r
            8'h62: v = 8'd8;     // b
            8'h74: v = 8'd9;     // t
            8'h73: v = 8'd32;    // s
            8'h66: v = 8'd12;    // f
            8'h76: v = 8'd11;    // v
            8'h65: v = ESC_BYTE; // e
            default: v = c;
        endcase
        return v;
    endfunction

endpackage

### hdl/slu_decode.sv
// Decode state (mode, base, accumulator, terminator) and per-character logic.
// Depends on slu_pkg.
module slu_decode import slu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_go,
    input  logic [7:0] i_char,
    input  logic       i_start,
    output t_pair      o_res
);

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_TEXT = 2'd1;
    localparam logic [1:0] MODE_ESC  = 2'd2;
    localparam logic [1:0] MODE_NUM  = 2'd3;

    localparam logic [1:0] BASE_NONE = 2'd0;
    localparam logic [1:0] BASE_OCT  = 2'd1;
    localparam logic [1:0] BASE_DEC  = 2'd2;
    localparam logic [1:0] BASE_HEX  = 2'd3;

    logic [1:0] r_mode, n_mode;
    logic [1:0] r_base, n_base;
    logic [7:0] r_acc,  n_acc;
    logic [7:0] r_term, n_term;

    logic       tx_emit;
    t_result    tx_res;
    logic [1:0] tx_mode;
    logic [7:0] digit;
    logic [7:0] radix;
    logic [7:0] acc_step;

    // Plain text handling, also used for the character that ends a number.
    always_comb begin
        tx_emit = 1'b1;
        tx_res  = '{out_byte: 8'd0, kind: KIND_BYTE, last: 1'b1};
        tx_mode = MODE_TEXT;
        if (i_char == CHAR_NUL) begin
            tx_res.kind = KIND_ERROR;
            tx_mode     = MODE_IDLE;
        end else if (i_char == r_term) begin
            tx_res.kind = KIND_CLOSE;
            tx_mode     = MODE_IDLE;
        end else if (i_char == CHAR_BSL) begin
            tx_emit = 1'b0;
            tx_mode = MODE_ESC;
        end else begin
            tx_res.out_byte = i_char;
        end
    end

    // Constant-base multiply-add, kept to 8 bits.
    always_comb begin
        digit = slu_digit(i_char);
        unique case (r_base)
            BASE_OCT: begin
                radix    = 8'd8;
                acc_step = {r_acc[4:0], 3'b000} + digit;
            end
            BASE_DEC: begin
                radix    = 8'd10;
                acc_step = {r_acc[4:0], 3'b000} + {r_acc[6:0], 1'b0} + digit;
            end
            BASE_HEX: begin
                radix    = 8'd16;
                acc_step = {r_acc[3:0], 4'b0000} + digit;
            end
            default: begin
                radix    = 8'd0;
                acc_step = r_acc;
            end
        endcase
    end

    always_comb begin
        n_mode = r_mode;
        n_base = r_base;
        n_acc  = r_acc;
        n_term = r_term;
        o_res  = '0;
        if (i_start) begin
            n_term = i_char;
            n_acc  = 8'd0;
            n_base = BASE_NONE;
            n_mode = MODE_TEXT;
        end else begin
            unique case (r_mode)
                MODE_IDLE: begin
                end
                MODE_TEXT: begin
                    n_mode = tx_mode;
                    if (tx_emit) begin
                        o_res.count = 2'd1;
                        o_res.first = tx_res;
                    end
                end
                MODE_ESC: begin
                    if (i_char == CHAR_NUL) begin
                        o_res.count = 2'd1;
                        o_res.first = '{out_byte: 8'd0, kind: KIND_ERROR, last: 1'b1};
                        n_mode      = MODE_IDLE;
                    end else if (i_char == 8'h78 || i_char == 8'h58 || i_char == 8'h30) begin
                        n_base = (i_char == 8'h30) ? BASE_OCT : BASE_HEX;
                        n_acc  = 8'd0;
                        n_mode = MODE_NUM;
                    end else if (i_char >= 8'h31 && i_char <= 8'h39) begin
                        n_base = BASE_DEC;
                        n_acc  = i_char - 8'h30;
                        n_mode = MODE_NUM;
                    end else begin
                        o_res.count = 2'd1;
                        o_res.first = '{out_byte: slu_escape(i_char), kind: KIND_BYTE,
                                        last: 1'b1};
                        n_mode      = MODE_TEXT;
                    end
                end
                MODE_NUM: begin
                    if (i_char == CHAR_NUL) begin
                        o_res.count = 2'd1;
                        o_res.first = '{out_byte: 8'd0, kind: KIND_ERROR, last: 1'b1};
                        n_mode      = MODE_IDLE;
                    end else if (digit < radix) begin
                        n_acc = acc_step;
                    end else begin
                        // emit the value, then handle the ending character as text
                        o_res.first = '{out_byte: r_acc, kind: KIND_BYTE, last: !tx_emit};
                        o_res.count = tx_emit ? 2'd2 : 2'd1;
                        o_res.second = tx_res;
                        n_mode = tx_mode;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_base <= BASE_NONE;
            r_acc  <= 8'd0;
            r_term <= 8'd0;
        end else if (i_go) begin
            r_mode <= n_mode;
            r_base <= n_base;
            r_acc  <= n_acc;
            r_term <= n_term;
        end
    end

endmodule

### hdl/slu_out_fifo.sv
// Four-entry result queue: takes up to two results a cycle, delivers one while the output is not stalled.
// Depends on slu_pkg.
module slu_out_fifo import slu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_pair      i_res,
    output logic       o_room2,
    output logic       o_valid,
    input  logic       i_stall,
    output t_result    o_res
);

    t_result    r_mem [4];
    logic [1:0] r_wr, n_wr;
    logic [1:0] r_rd, n_rd;
    logic [2:0] r_count, n_count;
    logic [1:0] push_cnt;
    logic       pop;

    assign push_cnt = i_push ? i_res.count : 2'd0;
    assign pop      = (r_count != 3'd0) && !i_stall;
    assign o_valid  = (r_count != 3'd0);
    assign o_room2  = (r_count <= 3'd2);
    assign o_res    = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr + push_cnt;
        n_rd    = r_rd + {1'b0, pop};
        n_count = r_count + {1'b0, push_cnt} - {2'b00, pop};
    end

    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_mem[r_wr] <= i_res.first;
        end
        if (push_cnt == 2'd2) begin
            r_mem[r_wr + 2'd1] <= i_res.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 2'd0;
            r_rd    <= 2'd0;
            r_count <= 3'd0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

### hdl/string_literal_unescaper.sv
// Top level of the string literal unescaper: input register, decode, result queue.
// Depends on slu_pkg, slu_decode and slu_out_fifo.
//
//   channel  handshake                 payload
//   input    i_in_valid / o_in_stall   i_in_byte, i_start_literal
//   output   o_out_valid / i_out_stall o_out_byte, o_kind, o_last
//
// A request is registered, then decoded from that register, and its results land in a
// four-entry queue: one request per cycle while the queue has room for two results.
// A request that yields two results is delivered one result at a time; the queue
// depth sets how long input keeps flowing under that load or an output stall.
// Synchronous active-low reset returns to idle with an empty queue.
module string_literal_unescaper import slu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_start_literal,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_kind,
    output logic       o_last
);

    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;
    logic       go;
    logic       room2;
    logic       accept;
    t_pair      res;
    t_result    head;

    assign go         = r_in_valid && room2;
    assign o_in_stall = r_in_valid && !go;
    assign accept     = i_in_valid && !o_in_stall;
    assign n_in_valid = accept || (r_in_valid && !go);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte  <= i_in_byte;
            r_in_start <= i_start_literal;
        end
    end

    slu_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_char  (r_in_byte),
        .i_start (r_in_start),
        .o_res   (res)
    );

    slu_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (go),
        .i_res   (res),
        .o_room2 (room2),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (head)
    );

    assign o_out_byte = head.out_byte;
    assign o_kind     = head.kind;
    assign o_last     = head.last;

endmodule
